### hw/rtl/zrs_pkg.sv
`timescale 1ns / 1ps

package zrs_pkg;

  // Default number of zones held by the sequencer.
  localparam int ZONE_COUNT_DEF = 6;

  // Field widths of a request and a result.
  localparam int CMD_W  = 2;
  localparam int ZIDX_W = 3;
  localparam int DUR_W  = 32;
  localparam int PCT_W  = 10;
  localparam int EV_W   = 2;
  localparam int PROD_W = DUR_W + PCT_W;

  // The percent scale. A run time of P = duration * percent lasts P / 100 ticks.
  localparam logic [PROD_W-1:0] PCT_DIV     = PROD_W'(100);
  localparam logic [PROD_W-1:0] PCT_DIV_TWO = PROD_W'(200);

  // Request command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd3;

  // Result event codes.
  localparam logic [EV_W-1:0] EV_NONE     = 2'd0;
  localparam logic [EV_W-1:0] EV_STARTED  = 2'd1;
  localparam logic [EV_W-1:0] EV_FINISHED = 2'd2;
  localparam logic [EV_W-1:0] EV_STOPPED  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ZIDX_W-1:0] zone_index;
    logic [DUR_W-1:0]  duration_ms;
    logic [PCT_W-1:0]  adjust_percent;
  } zrs_req_t;

  typedef struct packed {
    logic              running;
    logic              valve_open;
    logic [ZIDX_W-1:0] open_zone;
    logic [EV_W-1:0]   event_res;
  } zrs_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load_wr;      // write the duration store
    logic            halt;         // close the valve and go idle
    logic            tick_dec;     // count one tick off the open zone
    logic            scan_start;   // latch percent, scan from zone zero
    logic            scan_resume;  // scan from the zone after the open one
    logic            mul;          // form the scaled time of the scanned zone
    logic            step;         // move the scan to the next zone
    logic            open;         // open the scanned zone
    logic            emit;         // present a result
    logic [EV_W-1:0] event_code;
  } zrs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic active;     // a zone is open
    logic idx_ok;     // load index lies inside the store
    logic tick_last;  // the next tick ends the open zone
    logic scan_end;   // the scan has passed the last zone
    logic prod_ok;    // scaled time of the scanned zone is at least PCT_DIV
  } zrs_stat_t;

endpackage

### hw/rtl/zrs_ctrl.sv
`timescale 1ns / 1ps

module zrs_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [zrs_pkg::CMD_W-1:0] command,
  input  zrs_pkg::zrs_stat_t       stat,
  output logic                     busy,
  output zrs_pkg::zrs_cmd_t        cmd
);
  import zrs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_CHK  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       from_start_r, from_start_nxt;

  assign busy = (state_r != ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt      = state_r;
    from_start_nxt = from_start_r;
    cmd            = '0;
    cmd.event_code = EV_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (command)
            CMD_LOAD: begin
              cmd.load_wr = !stat.active && stat.idx_ok;
              cmd.emit    = 1'b1;
            end
            CMD_START: begin
              cmd.scan_start = 1'b1;
              cmd.halt       = 1'b1;
              from_start_nxt = 1'b1;
              state_nxt      = ST_MUL;
            end
            CMD_STOP: begin
              cmd.halt = stat.active;
              cmd.emit = 1'b1;
              if (stat.active) begin
                cmd.event_code = EV_STOPPED;
              end
            end
            CMD_TICK: begin
              if (stat.active && stat.tick_last) begin
                cmd.scan_resume = 1'b1;
                from_start_nxt  = 1'b0;
                state_nxt       = ST_MUL;
              end else begin
                cmd.tick_dec = stat.active;
                cmd.emit     = 1'b1;
              end
            end
            default: begin
              cmd.emit = 1'b1;
            end
          endcase
        end
      end
      ST_MUL: begin
        // Past the last zone the run is over.
        if (stat.scan_end) begin
          cmd.halt       = 1'b1;
          cmd.emit       = 1'b1;
          cmd.event_code = EV_FINISHED;
          state_nxt      = ST_IDLE;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (stat.prod_ok) begin
          cmd.open       = 1'b1;
          cmd.emit       = 1'b1;
          cmd.event_code = from_start_r ? EV_STARTED : EV_NONE;
          state_nxt      = ST_IDLE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      from_start_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      from_start_r <= from_start_nxt;
    end
  end

endmodule

### hw/rtl/zrs_dpath.sv
`timescale 1ns / 1ps

module zrs_dpath #(
  parameter int ZONE_COUNT = zrs_pkg::ZONE_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  zrs_pkg::zrs_req_t    req,
  input  zrs_pkg::zrs_cmd_t    cmd,
  output zrs_pkg::zrs_stat_t   stat,
  output logic                 out_strobe,
  output zrs_pkg::zrs_res_t    out_res
);
  import zrs_pkg::*;

  // Scan counter holds ZONE_COUNT itself; store index needs only the depth.
  localparam int ZW  = $clog2(ZONE_COUNT + 1);
  localparam int ZIW = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;

  logic [DUR_W-1:0]  dur_r [ZONE_COUNT];
  logic [PCT_W-1:0]  pct_r;
  logic [ZW-1:0]     scan_r, scan_nxt;
  logic [ZW-1:0]     cur_r, cur_nxt;
  logic              active_r, active_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] resid_r, resid_nxt;
  logic              strobe_r;
  zrs_res_t          res_r;

  logic [ZIW+ZIDX_W-1:0] load_idx;
  logic [ZW+ZIDX_W-1:0]  cur_ext;

  assign load_idx = {{ZIW{1'b0}}, req.zone_index};
  assign cur_ext  = {{ZIDX_W{1'b0}}, cur_nxt};

  // Status towards the controller.
  always_comb begin
    stat.active    = active_r;
    stat.idx_ok    = (32'(req.zone_index) < 32'(ZONE_COUNT));
    stat.tick_last = (resid_r < PCT_DIV_TWO);
    stat.scan_end  = (32'(scan_r) >= 32'(ZONE_COUNT));
    stat.prod_ok   = (prod_r >= PCT_DIV);
  end

  // Run state updates.
  always_comb begin
    active_nxt = active_r;
    cur_nxt    = cur_r;
    resid_nxt  = resid_r;
    scan_nxt   = scan_r;
    if (cmd.halt) begin
      active_nxt = 1'b0;
      cur_nxt    = '0;
      resid_nxt  = '0;
    end
    if (cmd.tick_dec) begin
      resid_nxt = resid_r - PCT_DIV;
    end
    if (cmd.scan_start) begin
      scan_nxt = '0;
    end
    if (cmd.scan_resume) begin
      scan_nxt = cur_r + ZW'(1);
    end
    if (cmd.step) begin
      scan_nxt = scan_r + ZW'(1);
    end
    if (cmd.open) begin
      active_nxt = 1'b1;
      cur_nxt    = scan_r;
      resid_nxt  = prod_r;
    end
  end

  // Duration store, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ZONE_COUNT; i++) begin
        dur_r[i] <= '0;
      end
    end else if (cmd.load_wr) begin
      dur_r[load_idx[ZIW-1:0]] <= req.duration_ms;
    end
  end

  // Scaled time of the scanned zone.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(dur_r[scan_r[ZIW-1:0]]) * PROD_W'(pct_r);
    end
  end

  // Run registers and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r    <= '0;
      scan_r   <= '0;
      cur_r    <= '0;
      active_r <= 1'b0;
      resid_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        pct_r <= req.adjust_percent;
      end
      scan_r   <= scan_nxt;
      cur_r    <= cur_nxt;
      active_r <= active_nxt;
      resid_r  <= resid_nxt;
      strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_r.running    <= active_nxt;
      res_r.valve_open <= active_nxt;
      res_r.open_zone  <= active_nxt ? cur_ext[ZIDX_W-1:0] : '0;
      res_r.event_res  <= cmd.event_code;
    end
  end

  assign out_strobe = strobe_r;
  assign out_res    = res_r;

endmodule

### hw/rtl/zone_run_sequencer_unit.sv
`timescale 1ns / 1ps
// Load, stop and ticks that do not end a zone give their result in the cycle after the request.
// Start, and a tick that ends a zone, scan the zones with one shared 32x10 multiplier,
// each zone passing a multiply state and a check state; the result follows the check state
// of the zone that opens, or the multiply state that finds the scan past the last zone.
// busy stays high until the result is shown; the receiver cannot stall.
// Synchronous active-low reset clears the duration store, the run state and the controller.
module zone_run_sequencer_unit #(
  parameter int ZONE_COUNT = zrs_pkg::ZONE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  zrs_pkg::zrs_req_t in_req,
  output logic              out_strobe,
  output zrs_pkg::zrs_res_t out_res
);
  import zrs_pkg::*;

  zrs_cmd_t  cmd;
  zrs_stat_t stat;

  // Sequence controller.
  zrs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .command (in_req.command),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  // Duration store, scaling multiplier and tick counter.
  zrs_dpath #(
    .ZONE_COUNT (ZONE_COUNT)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (in_req),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule
